[sv/arp_pkg.sv]
// ----------------------------------------------------------------------------
// arp_pkg: shared definitions for the anomaly report policy core
// Action codes, register indexes, default widths and reset values, and
// the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned LEVEL_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 48;
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  // Fixed register and port widths
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RUN_CFG_W  = 8;
  localparam int unsigned INTV_W     = 32;

  // Register reset values
  localparam logic                 DETECT_EN_RST  = 1'b1;
  localparam logic                 COMBINE_OR_RST = 1'b1;
  localparam logic [RUN_CFG_W-1:0] ENTER_RST      = 8'd3;
  localparam logic [RUN_CFG_W-1:0] RECOVER_RST    = 8'd3;
  localparam logic [INTV_W-1:0]    INTERVAL_RST   = 32'd1000000;

  typedef enum logic [1:0] {
    ACT_DISCARD = 2'd0,
    ACT_START   = 2'd1,
    ACT_REPORT  = 2'd2,
    ACT_RECOVER = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_EN   = 3'd0,
    CFG_RMS_THR     = 3'd1,
    CFG_PEAK_THR    = 3'd2,
    CFG_COMBINE_OR  = 3'd3,
    CFG_ENTER_WIN   = 3'd4,
    CFG_RECOVER_WIN = 3'd5,
    CFG_INTERVAL    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/arp_rem_div.sv]
// ----------------------------------------------------------------------------
// arp_rem_div: bit-serial remainder unit
// Restoring division that keeps only the remainder, one dividend bit per
// cycle through a single compare and subtract.
// ----------------------------------------------------------------------------
module arp_rem_div #(
  parameter int unsigned DIVIDEND_W = arp_pkg::TIME_WIDTH_DEF,
  parameter int unsigned DIVISOR_W  = arp_pkg::INTV_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output arp_pkg::div_stat_t    stat_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    dvs_ext;

  assign shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign dvs_ext = {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where it fits
      if (shifted >= dvs_ext) begin
        rem_d = DIVISOR_W'(shifted - dvs_ext);
      end else begin
        rem_d = shifted[DIVISOR_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

[sv/anomaly_report_policy_core.sv]
// ----------------------------------------------------------------------------
// anomaly_report_policy_core: vibration window anomaly reporting policy
// Classifies each window against the level thresholds, tracks the normal
// and anomaly runs, and schedules periodic reports while anomalous.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  window   | in_valid_i / in_ready_o + fields      | in
//  result   | out_valid_o / out_ready_i + fields    | out
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i      | in
//
// A window passes the evaluate and emit states from request to result, and the
// divide and fix states when a periodic report is due with a nonzero interval:
// the report-time catch-up runs the remainder unit, one lateness bit per cycle.
// in_ready_o is high only while no window is in work; a new window may be
// taken while the previous result still waits in the output register.
// Reset is asynchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module anomaly_report_policy_core #(
  parameter int unsigned LEVEL_WIDTH = arp_pkg::LEVEL_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = arp_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = arp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // window input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           window_valid_i,
  input  logic [LEVEL_WIDTH-1:0]         rms_level_i,
  input  logic [LEVEL_WIDTH-1:0]         peak_level_i,
  input  logic [TIME_WIDTH-1:0]          uptime_us_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           policy_state_o,
  output logic [1:0]                     action_o,
  output logic [COUNT_WIDTH-1:0]         anomaly_run_o,
  output logic [COUNT_WIDTH-1:0]         normal_run_o
);

  localparam int unsigned INTV_W = arp_pkg::INTV_W;
  localparam int unsigned RUN_W  = arp_pkg::RUN_CFG_W;
  localparam int unsigned CMP_W  = (COUNT_WIDTH > RUN_W) ? COUNT_WIDTH : RUN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // configuration registers
  logic                   detect_en_q;
  logic [LEVEL_WIDTH-1:0] rms_thr_q;
  logic [LEVEL_WIDTH-1:0] peak_thr_q;
  logic                   combine_or_q;
  logic [RUN_W-1:0]       enter_win_q;
  logic [RUN_W-1:0]       recover_win_q;
  logic [INTV_W-1:0]      interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_en_q   <= arp_pkg::DETECT_EN_RST;
      rms_thr_q     <= '0;
      peak_thr_q    <= '0;
      combine_or_q  <= arp_pkg::COMBINE_OR_RST;
      enter_win_q   <= arp_pkg::ENTER_RST;
      recover_win_q <= arp_pkg::RECOVER_RST;
      interval_q    <= arp_pkg::INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (arp_pkg::cfg_idx_e'(cfg_idx_i))
        arp_pkg::CFG_DETECT_EN:   detect_en_q   <= cfg_wdata_i[0];
        arp_pkg::CFG_RMS_THR:     rms_thr_q     <= cfg_wdata_i[LEVEL_WIDTH-1:0];
        arp_pkg::CFG_PEAK_THR:    peak_thr_q    <= cfg_wdata_i[LEVEL_WIDTH-1:0];
        arp_pkg::CFG_COMBINE_OR:  combine_or_q  <= cfg_wdata_i[0];
        arp_pkg::CFG_ENTER_WIN:   enter_win_q   <= cfg_wdata_i[RUN_W-1:0];
        arp_pkg::CFG_RECOVER_WIN: recover_win_q <= cfg_wdata_i[RUN_W-1:0];
        arp_pkg::CFG_INTERVAL:    interval_q    <= cfg_wdata_i[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and policy state
  state_e                 state_q, state_d;
  logic                   mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] anom_cnt_q, anom_cnt_d;
  logic [COUNT_WIDTH-1:0] norm_cnt_q, norm_cnt_d;
  logic [TIME_WIDTH-1:0]  next_rpt_q, next_rpt_d;
  arp_pkg::action_e       act_q, act_d;

  // captured request
  logic                   win_valid_q;
  logic [LEVEL_WIDTH-1:0] rms_q;
  logic [LEVEL_WIDTH-1:0] peak_q;
  logic [TIME_WIDTH-1:0]  now_q;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   out_state_q;
  arp_pkg::action_e       out_act_q;
  logic [COUNT_WIDTH-1:0] out_anom_q;
  logic [COUNT_WIDTH-1:0] out_norm_q;
  logic                   out_load;

  logic                   in_accept;
  logic                   rms_hit, peak_hit, anom;
  logic [COUNT_WIDTH-1:0] anom_inc, norm_inc;
  logic [TIME_WIDTH:0]    diff;
  logic                   div_start;
  arp_pkg::div_stat_t     div_stat;
  logic [INTV_W-1:0]      div_rem;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign rms_hit  = (rms_thr_q != '0) && (rms_q >= rms_thr_q);
  assign peak_hit = (peak_thr_q != '0) && (peak_q >= peak_thr_q);
  assign anom     = detect_en_q && (combine_or_q ? (rms_hit || peak_hit)
                                                 : (rms_hit && peak_hit));

  // saturate at all ones
  assign anom_inc = (anom_cnt_q == '1) ? anom_cnt_q : anom_cnt_q + 1'b1;
  assign norm_inc = (norm_cnt_q == '1) ? norm_cnt_q : norm_cnt_q + 1'b1;

  // borrow bit set when uptime lies below the next report time
  assign diff = {1'b0, now_q} - {1'b0, next_rpt_q};

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    anom_cnt_d = anom_cnt_q;
    norm_cnt_d = norm_cnt_q;
    next_rpt_d = next_rpt_q;
    act_d      = act_q;
    div_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        act_d   = arp_pkg::ACT_DISCARD;
        state_d = S_EMIT;
        if (win_valid_q) begin
          if (!mode_q) begin
            anom_cnt_d = anom ? anom_inc : '0;
            if ((enter_win_q != '0) &&
                (CMP_W'(anom_cnt_d) >= CMP_W'(enter_win_q))) begin
              mode_d     = 1'b1;
              norm_cnt_d = '0;
              next_rpt_d = now_q + TIME_WIDTH'(interval_q);
              act_d      = arp_pkg::ACT_START;
            end
          end else begin
            norm_cnt_d = anom ? '0 : norm_inc;
            if ((recover_win_q != '0) &&
                (CMP_W'(norm_cnt_d) >= CMP_W'(recover_win_q))) begin
              mode_d     = 1'b0;
              anom_cnt_d = '0;
              norm_cnt_d = '0;
              act_d      = arp_pkg::ACT_RECOVER;
            end else if (!diff[TIME_WIDTH]) begin
              act_d = arp_pkg::ACT_REPORT;
              if (interval_q != '0) begin
                // catch up: next becomes now - (now - next) mod interval + interval
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          next_rpt_d = now_q - TIME_WIDTH'(div_rem);
          state_d    = S_FIX;
        end
      end
      S_FIX: begin
        next_rpt_d = next_rpt_q + TIME_WIDTH'(interval_q);
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      anom_cnt_q  <= '0;
      norm_cnt_q  <= '0;
      next_rpt_q  <= '0;
      act_q       <= arp_pkg::ACT_DISCARD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      anom_cnt_q  <= anom_cnt_d;
      norm_cnt_q  <= norm_cnt_d;
      next_rpt_q  <= next_rpt_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      win_valid_q <= window_valid_i;
      rms_q       <= rms_level_i;
      peak_q      <= peak_level_i;
      now_q       <= uptime_us_i;
    end
    if (out_load) begin
      out_state_q <= mode_q;
      out_act_q   <= act_q;
      out_anom_q  <= anom_cnt_q;
      out_norm_q  <= norm_cnt_q;
    end
  end

  arp_rem_div #(
    .DIVIDEND_W (TIME_WIDTH),
    .DIVISOR_W  (INTV_W)
  ) u_rem_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff[TIME_WIDTH-1:0]),
    .divisor_i  (interval_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  assign out_valid_o    = out_valid_q;
  assign policy_state_o = out_state_q;
  assign action_o       = out_act_q;
  assign anomaly_run_o  = out_anom_q;
  assign normal_run_o   = out_norm_q;

  // no new request while the remainder unit runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("request taken while remainder unit busy");

  // remainder result only lands while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("remainder done outside of wait state");

  // start and report leave the anomaly state set, recovery clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((action_o == arp_pkg::ACT_START) ||
                     (action_o == arp_pkg::ACT_REPORT))) |-> policy_state_o)
    else $error("start or report with normal state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == arp_pkg::ACT_RECOVER)) |->
      (!policy_state_o && (anomaly_run_o == '0) && (normal_run_o == '0)))
    else $error("recovery without cleared state");

endmodule
